@@ rtl/core/cawf_pkg.sv @@
// Package of the byte/word ALU with status flags.
// Holds the operation codes, the item and result types and the flag bit positions.
// No dependencies.
package cawf_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagP = 1;
  localparam int unsigned FlagH = 2;
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagS = 4;
  localparam int unsigned FlagV = 5;

  typedef enum logic [4:0] {
    OP_ADC  = 5'd0,
    OP_ADD  = 5'd1,
    OP_AND  = 5'd2,
    OP_DEC  = 5'd3,
    OP_DIV  = 5'd4,
    OP_DIVI = 5'd5,
    OP_INC  = 5'd6,
    OP_MUL  = 5'd7,
    OP_MULI = 5'd8,
    OP_NEG  = 5'd9,
    OP_NOT  = 5'd10,
    OP_OR   = 5'd11,
    OP_RCL  = 5'd12,
    OP_RCR  = 5'd13,
    OP_ROL  = 5'd14,
    OP_ROR  = 5'd15,
    OP_SAL  = 5'd16,
    OP_SAR  = 5'd17,
    OP_SBB  = 5'd18,
    OP_SHL  = 5'd19,
    OP_SHR  = 5'd20,
    OP_SUB  = 5'd21,
    OP_XOR  = 5'd22
  } op_e;

  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_DIV,
    CLS_RC
  } cls_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_RC
  } back_state_e;

  typedef struct packed {
    logic [4:0]  mode;
    logic        word;
    logic [31:0] a;
    logic [15:0] b;
    logic [5:0]  flags;
    cls_e        cls;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  flags;
    logic        derr;
  } res_t;

endpackage

@@ rtl/core/cpu_alu_with_flags_core.sv @@
// Byte/word ALU with status flags: front end, item queue and execution back end.
// A simple result is strobed in the cycle after its item leaves the queue; divide uses
// the one-bit-per-cycle divider and rcl/rcr rotate one place per step. Other operations
// sustain one item per cycle unless a divide or rcl/rcr is busy. Reset empties the queue
// and idles the back end. Results are strobed for one cycle; the receiver cannot stall.
module cpu_alu_with_flags_core #(
  parameter int unsigned QueueDepth = cawf_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  mode_i,
  input  logic        width_word_i,
  input  logic [31:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic [5:0]  flags_in_i,
  output logic        result_valid_o,
  output logic [31:0] result_value_o,
  output logic [5:0]  flags_out_o,
  output logic        divide_error_o
);
  import cawf_pkg::*;

  item_t front_item, head_item;
  logic  q_full, q_empty, q_pop;

  assign busy = q_full;

  cawf_front u_front (
    .mode_i       (mode_i),
    .width_word_i (width_word_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .flags_in_i   (flags_in_i),
    .item_o       (front_item)
  );

  cawf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (head_item)
  );

  cawf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .item_i         (head_item),
    .pop_o          (q_pop),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .flags_out_o    (flags_out_o),
    .divide_error_o (divide_error_o)
  );

endmodule

@@ rtl/core/cawf_front.sv @@
// Front end of the ALU: turns an accepted input beat into a classified queue item.
// Depends on cawf_pkg.
module cawf_front (
  input  logic [4:0]    mode_i,
  input  logic          width_word_i,
  input  logic [31:0]   operand_a_i,
  input  logic [15:0]   operand_b_i,
  input  logic [5:0]    flags_in_i,
  output cawf_pkg::item_t item_o
);
  import cawf_pkg::*;

  logic [15:0] y;
  logic        y_zero;

  assign y      = width_word_i ? operand_b_i : {8'h00, operand_b_i[7:0]};
  assign y_zero = (y == 16'h0000);

  always_comb begin
    item_o.mode  = mode_i;
    item_o.word  = width_word_i;
    item_o.a     = operand_a_i;
    item_o.b     = operand_b_i;
    item_o.flags = flags_in_i;
    item_o.cls   = CLS_SIMPLE;
    if ((mode_i == OP_DIV || mode_i == OP_DIVI) && !y_zero) begin
      item_o.cls = CLS_DIV;
    end else if ((mode_i == OP_RCL || mode_i == OP_RCR) && operand_b_i[4:0] != 5'd0) begin
      item_o.cls = CLS_RC;
    end
  end

endmodule

@@ rtl/core/cawf_queue.sv @@
// Short queue of classified items between the front end and the execution back end.
// Depends on cawf_pkg.
module cawf_queue #(
  parameter int unsigned Depth = cawf_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cawf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cawf_pkg::item_t item_o
);
  import cawf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

@@ rtl/core/cawf_back.sv @@
// Execution back end: combinational simple operations, iterative divide and rotate through carry.
// Depends on cawf_pkg; takes items from cawf_queue.
module cawf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  cawf_pkg::item_t item_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output logic [31:0]     result_value_o,
  output logic [5:0]      flags_out_o,
  output logic            divide_error_o
);
  import cawf_pkg::*;

  function automatic logic msb_of(logic [15:0] v, logic word);
    return word ? v[15] : v[7];
  endfunction

  function automatic logic [5:0] set_pzs(logic [5:0] f, logic [15:0] r, logic word);
    logic [5:0] g;
    g        = f;
    g[FlagP] = ~^r[7:0];
    g[FlagZ] = word ? (r == 16'h0000) : (r[7:0] == 8'h00);
    g[FlagS] = msb_of(r, word);
    return g;
  endfunction

  function automatic res_t exec_simple(item_t it);
    logic [15:0]        x, y, mask, r;
    logic [5:0]         f;
    logic               c, w;
    logic [16:0]        s;
    logic [4:0]         h, cnt;
    logic [31:0]        p, sx, sh, rot;
    logic signed [31:0] ps;
    logic [15:0]        xs, ys;
    logic [47:0]        wide;
    res_t               res;
    w     = it.word;
    mask  = w ? 16'hffff : 16'h00ff;
    x     = it.a[15:0] & mask;
    y     = it.b & mask;
    f     = it.flags;
    cnt   = it.b[4:0];
    c     = 1'b0;
    r     = 16'h0000;
    s     = '0;
    h     = '0;
    p     = '0;
    ps    = '0;
    sx    = '0;
    sh    = '0;
    rot   = '0;
    wide  = '0;
    xs    = w ? x : {{8{x[7]}}, x[7:0]};
    ys    = w ? y : {{8{y[7]}}, y[7:0]};
    res.value = 32'h0;
    res.derr  = 1'b0;
    case (it.mode)
      OP_ADC, OP_ADD: begin
        c        = (it.mode == OP_ADC) ? f[FlagC] : 1'b0;
        s        = {1'b0, x} + {1'b0, y} + {16'h0, c};
        r        = s[15:0] & mask;
        h        = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'h0, c};
        f[FlagC] = w ? s[16] : s[8];
        f[FlagH] = h[4];
        f        = set_pzs(f, r, w);
        f[FlagV] = msb_of((r ^ x) & (r ^ y), w);
        res.value = {16'h0, r};
      end
      OP_SBB, OP_SUB: begin
        c        = (it.mode == OP_SBB) ? f[FlagC] : 1'b0;
        r        = (x - y - {15'h0, c}) & mask;
        f[FlagC] = ({1'b0, y} + {16'h0, c}) > {1'b0, x};
        f[FlagH] = ({1'b0, y[3:0]} + {4'h0, c}) > {1'b0, x[3:0]};
        f        = set_pzs(f, r, w);
        f[FlagV] = msb_of((x ^ y) & (x ^ r), w);
        res.value = {16'h0, r};
      end
      OP_AND, OP_OR, OP_XOR: begin
        r = (it.mode == OP_AND) ? (x & y) : (it.mode == OP_OR) ? (x | y) : (x ^ y);
        f[FlagC] = 1'b0;
        f[FlagH] = 1'b0;
        f[FlagV] = 1'b0;
        f        = set_pzs(f, r, w);
        res.value = {16'h0, r};
      end
      OP_DEC: begin
        r        = (x - 16'h1) & mask;
        f[FlagH] = (x[3:0] == 4'h0);
        f        = set_pzs(f, r, w);
        f[FlagV] = w ? (r == 16'h7fff) : (r[7:0] == 8'h7f);
        res.value = {16'h0, r};
      end
      OP_INC: begin
        r        = (x + 16'h1) & mask;
        f[FlagH] = (x[3:0] == 4'hf);
        f        = set_pzs(f, r, w);
        f[FlagV] = w ? (r == 16'h8000) : (r[7:0] == 8'h80);
        res.value = {16'h0, r};
      end
      OP_DIV, OP_DIVI: begin
        res.derr = 1'b1;
      end
      OP_MUL: begin
        p        = x * y;
        c        = w ? (p[31:16] != 16'h0) : (p[15:8] != 8'h0);
        f[FlagC] = c;
        f[FlagV] = c;
        res.value = p;
      end
      OP_MULI: begin
        ps       = $signed(xs) * $signed(ys);
        p        = ps;
        c        = w ? !(p[31:15] == 17'h0 || p[31:15] == 17'h1ffff)
                     : !(p[31:7] == 25'h0 || p[31:7] == 25'h1ffffff);
        f[FlagC] = c;
        f[FlagV] = c;
        res.value = p;
      end
      OP_NEG: begin
        r        = (16'h0 - x) & mask;
        f[FlagC] = (x != 16'h0);
        f[FlagH] = (x[3:0] != 4'h0);
        f        = set_pzs(f, r, w);
        f[FlagV] = w ? (x == 16'h8000) : (x[7:0] == 8'h80);
        res.value = {16'h0, r};
      end
      OP_NOT: begin
        res.value = {16'h0, ~x & mask};
      end
      OP_RCL, OP_RCR: begin
        f[FlagV] = 1'b0;
        res.value = {16'h0, x};
      end
      OP_ROL, OP_ROR: begin
        if (w) begin
          rot = (it.mode == OP_ROL) ? ({x, x} << it.b[3:0]) : ({x, x} >> it.b[3:0]);
          r   = (it.mode == OP_ROL) ? rot[31:16] : rot[15:0];
        end else begin
          rot = (it.mode == OP_ROL) ? ({16'h0, x[7:0], x[7:0]} << it.b[2:0])
                                    : ({16'h0, x[7:0], x[7:0]} >> it.b[2:0]);
          r   = (it.mode == OP_ROL) ? {8'h0, rot[15:8]} : {8'h0, rot[7:0]};
        end
        if (it.b[3:0] != 4'h0) begin
          f[FlagC] = (it.mode == OP_ROL) ? r[0] : msb_of(r, w);
        end
        f[FlagV] = msb_of(x ^ r, w);
        res.value = {16'h0, r};
      end
      OP_SAL, OP_SHL: begin
        wide = {32'h0, x} << cnt;
        r    = wide[15:0] & mask;
        if (cnt != 5'd0) begin
          f[FlagC] = w ? wide[16] : wide[8];
        end
        f        = set_pzs(f, r, w);
        f[FlagV] = msb_of(x ^ r, w);
        res.value = {16'h0, r};
      end
      OP_SHR: begin
        r  = x >> cnt;
        sh = {16'h0, x} >> (cnt - 5'd1);
        if (cnt != 5'd0) begin
          f[FlagC] = sh[0];
        end
        f        = set_pzs(f, r, w);
        f[FlagV] = msb_of(x ^ r, w);
        res.value = {16'h0, r};
      end
      OP_SAR: begin
        sx = w ? {{16{x[15]}}, x} : {{24{x[7]}}, x[7:0]};
        if (cnt[4]) begin
          f[FlagC] = msb_of(x, w);
          r        = msb_of(x, w) ? mask : 16'h0;
        end else begin
          sh = sx >> cnt;
          r  = sh[15:0] & mask;
          sh = sx >> (cnt - 5'd1);
          if (cnt != 5'd0) begin
            f[FlagC] = sh[0];
          end
          f        = set_pzs(f, r, w);
          f[FlagV] = 1'b0;
        end
        res.value = {16'h0, r};
      end
      default: begin
        res.value = 32'h0;
      end
    endcase
    res.flags = f;
    return res;
  endfunction

  back_state_e state_q, state_d;
  item_t       it_q;
  logic [5:0]  step_q, step_d;
  logic [31:0] dq_q, dq_d;
  logic [15:0] rem_q, rem_d, dv_q, dv_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;
  logic [15:0] rc_q, rc_d;
  logic        rcc_q, rcc_d;
  logic        load;
  logic        finish;
  res_t        simple_res, done_res;

  logic        is_signed, sa, sb;
  logic [31:0] dd_sx, dd_mag;
  logic [15:0] y_in, ys_in, dv_mag;
  logic [16:0] rem_sh, rem_sub;
  logic [31:0] q_fix;
  logic [15:0] r_fix;
  logic [15:0] rc_mask;

  assign pop_o      = (state_q == BK_IDLE) && !empty_i;
  assign load       = pop_o;
  assign simple_res = exec_simple(item_i);

  always_comb begin
    is_signed = (item_i.mode == OP_DIVI);
    y_in      = item_i.word ? item_i.b : {8'h00, item_i.b[7:0]};
    ys_in     = item_i.word ? item_i.b : {{8{item_i.b[7]}}, item_i.b[7:0]};
    dd_sx     = item_i.word ? item_i.a : {{16{item_i.a[15]}}, item_i.a[15:0]};
    sa        = is_signed && dd_sx[31];
    sb        = is_signed && ys_in[15];
    dd_mag    = is_signed ? (sa ? (32'h0 - dd_sx) : dd_sx)
                          : (item_i.word ? item_i.a : {16'h0, item_i.a[15:0]});
    dv_mag    = is_signed ? (sb ? (16'h0 - ys_in) : ys_in) : y_in;
  end

  always_comb begin
    rem_sh  = {rem_q, dq_q[31]};
    rem_sub = rem_sh - {1'b0, dv_q};
    rc_mask = it_q.word ? 16'hffff : 16'h00ff;
  end

  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (load && item_i.cls == CLS_DIV) begin
          state_d = BK_DIV;
        end else if (load && item_i.cls == CLS_RC) begin
          state_d = BK_RC;
        end
      end
      BK_DIV, BK_RC: begin
        if (step_q == 6'd1) begin
          state_d = BK_IDLE;
          finish  = 1'b1;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    rc_d   = rc_q;
    rcc_d  = rcc_q;
    case (state_q)
      BK_IDLE: begin
        if (load) begin
          dq_d   = item_i.word ? dd_mag : {dd_mag[15:0], 16'h0};
          rem_d  = 16'h0;
          dv_d   = dv_mag;
          qneg_d = sa ^ sb;
          rneg_d = sa;
          rc_d   = item_i.a[15:0] & (item_i.word ? 16'hffff : 16'h00ff);
          rcc_d  = item_i.flags[FlagC];
          step_d = (item_i.cls == CLS_DIV) ? (item_i.word ? 6'd32 : 6'd16)
                                           : {1'b0, item_i.b[4:0]};
        end
      end
      BK_DIV: begin
        step_d = step_q - 6'd1;
        if (!rem_sub[16]) begin
          rem_d = rem_sub[15:0];
          dq_d  = {dq_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh[15:0];
          dq_d  = {dq_q[30:0], 1'b0};
        end
      end
      BK_RC: begin
        step_d = step_q - 6'd1;
        if (it_q.mode == OP_RCL) begin
          rcc_d = msb_of(rc_q, it_q.word);
          rc_d  = {rc_q[14:0], rcc_q} & rc_mask;
        end else begin
          rcc_d = rc_q[0];
          rc_d  = {1'b0, rc_q[15:1]};
          if (it_q.word) begin
            rc_d[15] = rcc_q;
          end else begin
            rc_d[7] = rcc_q;
          end
        end
      end
      default: begin
        step_d = step_q;
      end
    endcase
  end

  always_comb begin
    q_fix          = qneg_q ? (32'h0 - dq_d) : dq_d;
    r_fix          = rneg_q ? (16'h0 - rem_d) : rem_d;
    done_res       = '0;
    done_res.flags = it_q.flags;
    if (state_q == BK_DIV) begin
      done_res.value = it_q.word ? {r_fix, q_fix[15:0]} : {16'h0, r_fix[7:0], q_fix[7:0]};
    end else begin
      done_res.value        = {16'h0, rc_d};
      done_res.flags[FlagC] = rcc_d;
      done_res.flags[FlagV] = msb_of((it_q.a[15:0] & rc_mask) ^ rc_d, it_q.word);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= finish || (load && item_i.cls == CLS_SIMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
    rc_q   <= rc_d;
    rcc_q  <= rcc_d;
    if (load) begin
      it_q <= item_i;
    end
    if (finish) begin
      result_value_o <= done_res.value;
      flags_out_o    <= done_res.flags;
      divide_error_o <= 1'b0;
    end else if (load && item_i.cls == CLS_SIMPLE) begin
      result_value_o <= simple_res.value;
      flags_out_o    <= simple_res.flags;
      divide_error_o <= simple_res.derr;
    end
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == BK_IDLE)
    else $error("back end took an item while busy");
  a_busy_no_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_IDLE && state_d != BK_IDLE) |=> !result_valid_o)
    else $error("result strobe while an item is still in progress");
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV || state_q == BK_RC) |-> step_q != 6'd0)
    else $error("iteration counter ran out");
`endif

endmodule

@@ sim/cpu_alu_with_flags_core_test.sv @@
// Testbench of the byte/word ALU with status flags: random and directed operations.
// A scoreboard class predicts each result in order and compares it field by field.
// Depends on cawf_pkg and cpu_alu_with_flags_core.
module cpu_alu_with_flags_core_test;
  import cawf_pkg::*;

  class alu_scoreboard;
    logic [31:0] exp_value[$];
    logic [5:0]  exp_flags[$];
    logic        exp_derr[$];
    int mismatches;
    int checked;

    function automatic bit even_par(logic [31:0] v);
      return ~^v[7:0];
    endfunction

    function automatic logic [5:0] pzs(logic [5:0] f, logic [31:0] r, logic [31:0] sgn);
      f[FlagP] = even_par(r);
      f[FlagZ] = (r == 0);
      f[FlagS] = (r & sgn) != 0;
      return f;
    endfunction

    function automatic longint sx(logic [31:0] v, int bits);
      longint m;
      longint x;
      m = longint'(1) << (bits - 1);
      x = longint'(v) & ((m << 1) - 1);
      return (x ^ m) - m;
    endfunction

    function void note_item(logic [4:0] mode, logic word, logic [31:0] a,
                            logic [15:0] b, logic [5:0] fin);
      int bits;
      logic [31:0] mask, sgn, x, y, c, s, r, dd, cnt, k, sxv;
      logic [5:0] f;
      logic derr;
      longint sdd, sdv, p;
      logic [63:0] w;
      bit cb, ob, wide;
      bits = word ? 16 : 8;
      mask = word ? 32'hffff : 32'hff;
      sgn = word ? 32'h8000 : 32'h80;
      x = a & mask;
      y = {16'd0, b} & mask;
      f = fin;
      cnt = {16'd0, b} & 32'd31;
      r = 0;
      derr = 1'b0;
      case (mode)
        OP_ADC, OP_ADD: begin
          c = (mode == OP_ADC) ? {31'd0, fin[FlagC]} : 32'd0;
          s = x + y + c;
          r = s & mask;
          f[FlagC] = s > mask;
          f[FlagH] = (x & 15) + (y & 15) + c >= 16;
          f = pzs(f, r, sgn);
          f[FlagV] = ((r ^ x) & (r ^ y) & sgn) != 0;
        end
        OP_SBB, OP_SUB: begin
          c = (mode == OP_SBB) ? {31'd0, fin[FlagC]} : 32'd0;
          r = (x - y - c) & mask;
          f[FlagC] = y + c > x;
          f[FlagH] = (y & 15) + c > (x & 15);
          f = pzs(f, r, sgn);
          f[FlagV] = ((x ^ y) & (x ^ r) & sgn) != 0;
        end
        OP_AND, OP_OR, OP_XOR: begin
          r = (mode == OP_AND) ? (x & y) : (mode == OP_OR) ? (x | y) : (x ^ y);
          f[FlagC] = 0;
          f[FlagH] = 0;
          f[FlagV] = 0;
          f = pzs(f, r, sgn);
        end
        OP_DEC: begin
          r = (x - 1) & mask;
          f[FlagH] = (x & 15) == 0;
          f = pzs(f, r, sgn);
          f[FlagV] = r == sgn - 1;
        end
        OP_INC: begin
          r = (x + 1) & mask;
          f[FlagH] = (x & 15) == 15;
          f = pzs(f, r, sgn);
          f[FlagV] = r == sgn;
        end
        OP_DIV: begin
          dd = word ? a : (a & 32'hffff);
          if (y == 0) derr = 1'b1;
          else r = (((dd % y) & mask) << bits) | ((dd / y) & mask);
        end
        OP_DIVI: begin
          sdd = sx(a, bits * 2);
          sdv = sx(y, bits);
          if (sdv == 0) derr = 1'b1;
          else r = ((32'(sdd % sdv) & mask) << bits) | (32'(sdd / sdv) & mask);
        end
        OP_MUL: begin
          r = x * y;
          f[FlagC] = (r >> bits) != 0;
          f[FlagV] = f[FlagC];
        end
        OP_MULI: begin
          p = sx(x, bits) * sx(y, bits);
          wide = p != sx(32'(p) & mask, bits);
          r = 32'(p);
          f[FlagC] = wide;
          f[FlagV] = wide;
        end
        OP_NEG: begin
          r = (0 - x) & mask;
          f[FlagC] = x != 0;
          f[FlagH] = (x & 15) != 0;
          f = pzs(f, r, sgn);
          f[FlagV] = x == sgn;
        end
        OP_NOT: r = ~x & mask;
        OP_RCL, OP_RCR: begin
          cb = fin[FlagC];
          r = x;
          for (int n = 0; n < cnt; n++) begin
            if (mode == OP_RCL) begin
              ob = (r & sgn) != 0;
              r = ((r << 1) | {31'd0, cb}) & mask;
            end else begin
              ob = r[0];
              r = (cb ? sgn : 32'd0) | (r >> 1);
            end
            cb = ob;
          end
          f[FlagC] = cb;
          f[FlagV] = ((x ^ r) & sgn) != 0;
        end
        OP_ROL, OP_ROR: begin
          k = ({16'd0, b} & 32'd15) % bits;
          if (k == 0) r = x;
          else if (mode == OP_ROL) r = ((x << k) | (x >> (bits - k))) & mask;
          else r = ((x >> k) | (x << (bits - k))) & mask;
          if (b[3:0] != 0) f[FlagC] = (mode == OP_ROL) ? r[0] : ((r & sgn) != 0);
          f[FlagV] = ((x ^ r) & sgn) != 0;
        end
        OP_SAL, OP_SHL: begin
          w = 64'(x) << cnt;
          r = 32'(w) & mask;
          if (cnt != 0) f[FlagC] = w[bits];
          f = pzs(f, r, sgn);
          f[FlagV] = ((x ^ r) & sgn) != 0;
        end
        OP_SHR: begin
          r = (x >> cnt) & mask;
          if (cnt != 0) f[FlagC] = ((x >> (cnt - 1)) & 1) != 0;
          f = pzs(f, r, sgn);
          f[FlagV] = ((x ^ r) & sgn) != 0;
        end
        OP_SAR: begin
          sxv = (x & sgn) ? (x | ~mask) : x;
          if (cnt[4]) begin
            f[FlagC] = (x & sgn) != 0;
            r = (x & sgn) ? mask : 32'd0;
          end else begin
            r = (sxv >> cnt) & mask;
            if (cnt != 0) f[FlagC] = ((sxv >> (cnt - 1)) & 1) != 0;
            f = pzs(f, r, sgn);
            f[FlagV] = 0;
          end
        end
        default: r = 0;
      endcase
      exp_value.push_back(r);
      exp_flags.push_back(f);
      exp_derr.push_back(derr);
    endfunction

    function void check_result(logic [31:0] v, logic [5:0] f, logic d);
      logic [31:0] ev;
      logic [5:0] ef;
      logic ed;
      if (exp_value.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat value %h", v);
        return;
      end
      ev = exp_value.pop_front();
      ef = exp_flags.pop_front();
      ed = exp_derr.pop_front();
      checked++;
      if (v !== ev || f !== ef || d !== ed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value %h/%h flags %h/%h derr %b/%b (expected/actual)",
                   ev, v, ef, f, ed, d);
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy;
  logic [4:0] mode_i;
  logic width_word_i;
  logic [31:0] operand_a_i;
  logic [15:0] operand_b_i;
  logic [5:0] flags_in_i;
  logic result_valid_o;
  logic [31:0] result_value_o;
  logic [5:0] flags_out_o;
  logic divide_error_o;

  alu_scoreboard sb;
  int idle_cycles;
  int sent;
  bit calm;
  bit timed_out;

  cpu_alu_with_flags_core DUT (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_value_o, flags_out_o, divide_error_o);
      if ((start && !busy) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        timed_out = 1;
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [4:0] m, logic wd, logic [31:0] a, logic [15:0] b,
                           logic [5:0] f);
    while (!calm && $urandom_range(99) < 31) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    mode_i <= m;
    width_word_i <= wd;
    operand_a_i <= a;
    operand_b_i <= b;
    flags_in_i <= f;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(m, wd, a, b, f);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_a();
    case ($urandom_range(4))
      0: return 32'hffffffff;
      1: return 0;
      2: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_b();
    case ($urandom_range(5))
      0: return 16'hffff;
      1: return 16'h0;
      2: return 16'($urandom_range(31));
      3: return 16'h8000 | 16'($urandom_range(31));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [4:0] m;
    sb = new();
    clk_i = 0;
    rst_ni = 0;
    start = 0;
    mode_i = 0;
    width_word_i = 0;
    operand_a_i = 0;
    operand_b_i = 0;
    flags_in_i = 0;
    idle_cycles = 0;
    calm = 0;
    timed_out = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_item(OP_ADD, 0, 32'hff, 16'h01, 6'h00);
    send_item(OP_ADC, 1, 32'hffff, 16'hffff, 6'h3f);
    send_item(OP_SBB, 1, 32'h0, 16'h0, 6'h01);
    send_item(OP_SUB, 0, 32'h80, 16'h01, 6'h00);
    send_item(OP_DIV, 0, 32'hffff, 16'h0, 6'h15);
    send_item(OP_DIVI, 1, 32'h80000000, 16'hffff, 6'h00);
    send_item(OP_DIVI, 0, 32'h8000, 16'hff, 6'h00);
    send_item(OP_DIV, 1, 32'hffffffff, 16'h1, 6'h2a);
    send_item(OP_MULI, 1, 32'h8000, 16'h8000, 6'h00);
    send_item(OP_MUL, 0, 32'hff, 16'hff, 6'h00);
    send_item(OP_NEG, 0, 32'h80, 16'h0, 6'h00);
    send_item(OP_NOT, 1, 32'h1234, 16'h0, 6'h3f);
    send_item(OP_SAR, 0, 32'h80, 16'h10, 6'h00);
    send_item(OP_SAR, 0, 32'h81, 16'h0c, 6'h00);
    send_item(OP_SHL, 1, 32'h8001, 16'h0, 6'h21);
    send_item(OP_RCL, 0, 32'h81, 16'h1f, 6'h01);
    send_item(OP_RCR, 1, 32'h8001, 16'h11, 6'h00);
    send_item(OP_ROL, 0, 32'h81, 16'h08, 6'h00);
    send_item(OP_ROR, 1, 32'h8001, 16'h0f, 6'h01);
    send_item(OP_INC, 0, 32'h7f, 16'h0, 6'h00);
    send_item(OP_DEC, 1, 32'h8000, 16'h0, 6'h00);
    send_item(5'd31, 1, 32'hffffffff, 16'hffff, 6'h3f);
    drain();
    for (int i = 0; i < 1050; i++) begin
      calm = (i >= 300 && i < 450);
      if (i == 600) drain();
      m = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(22));
      send_item(m, 1'($urandom_range(1)), pick_a(), pick_b(), 6'($urandom_range(63)));
    end
    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d items over all operations, both widths and edge operands.", sent);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0 && !timed_out) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/cawf_pkg.sv
rtl/core/cawf_front.sv
rtl/core/cawf_queue.sv
rtl/core/cawf_back.sv
rtl/core/cpu_alu_with_flags_core.sv
sim/cpu_alu_with_flags_core_test.sv
